// ----- rtl/core/nge_pkg.sv -----
// Shared types, register codes, constants and constant table functions for the noise gate.
`default_nettype none
package nge_pkg;

	localparam int ADDR_W = 5;
	localparam int MUL_W = 34;
	localparam int DB_LOWEST = -32768;
	localparam int DB_HIGHEST = 32767;

	localparam logic [15:0] THRESHOLD_RST = 16'hD300;
	localparam logic [14:0] RANGE_RST = 15'd10240;
	localparam logic [12:0] RATIO_RST = 13'd1024;
	localparam logic [15:0] ATTACK_RST = 16'd64186;
	localparam logic [15:0] RELEASE_RST = 16'd65524;
	localparam logic [16:0] HOLD_RST = 17'd1440;

	localparam logic [31:0] ENV_RST = 32'd1;
	localparam logic [17:0] GAIN_RST = 18'd1311;
	localparam logic [17:0] UNITY_GAIN = 18'd131072;
	localparam logic [14:0] DB_PER_OCTAVE_Q12 = 15'd24660;
	localparam logic [13:0] OCTAVE_PER_DB_Q16 = 14'd10885;
	localparam logic [12:0] RATIO_ONE = 13'd256;

	typedef struct packed {
		logic [15:0] threshold_db;
		logic [14:0] range_db;
		logic [12:0] ratio;
		logic [15:0] attack_coef;
		logic [15:0] release_coef;
		logic [16:0] hold_samples;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_THRESHOLD,
		REG_RANGE,
		REG_RATIO,
		REG_ATTACK,
		REG_RELEASE,
		REG_HOLD
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ENV_MUL,
		S_ENV_UPD,
		S_NORM,
		S_DB_MUL,
		S_DB,
		S_GR_MUL,
		S_GR,
		S_E_MUL,
		S_E,
		S_EXP_MUL,
		S_EXP_UPD,
		S_TGT,
		S_G_MUL,
		S_G_UPD,
		S_L_MUL,
		S_L_UPD,
		S_R_MUL,
		S_R_UPD
	} state_t;

	// Fractional part of log2(1 + idx / 2^bits) in Q0.16, by repeated squaring.
	function automatic logic [15:0] log2_frac(input int idx, input int bits);
		logic [63:0] x;
		logic [15:0] f;
		x = 64'((64'd1 << bits) + 64'(idx)) << (30 - bits);
		f = 16'd0;
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			f = f << 1;
			if (x >= (64'd1 << 31)) begin
				f = f | 16'd1;
				x = x >> 1;
			end
		end
		return f;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] bit_v;
		logic [63:0] xv;
		r = 64'd0;
		bit_v = 64'h4000_0000_0000_0000;
		xv = x;
		for (int i = 0; i < 32; i++) begin
			if (xv >= r + bit_v) begin
				xv = xv - (r + bit_v);
				r = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return r;
	endfunction

	// Factor 2^(-2^-k) in Q0.32, built as a chain of square roots of one half.
	function automatic logic [31:0] exp_root(input int k);
		logic [63:0] root;
		root = 64'd1 << 31;
		for (int j = 1; j <= k; j++) begin
			root = isqrt64(root << 32);
		end
		return root[31:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/nge_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none
module nge_mul (
	input  wire logic                                 clk,
	input  wire logic signed [nge_pkg::MUL_W-1:0]     a,
	input  wire logic signed [nge_pkg::MUL_W-1:0]     b,
	output logic signed [2*nge_pkg::MUL_W-1:0]        p_q
);
	import nge_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule
`default_nettype wire

// ----- rtl/core/nge_regs.sv -----
// APB-style configuration register file for the noise gate.
`default_nettype none
module nge_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [nge_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output nge_pkg::cfg_t                   cfg
);
	import nge_pkg::*;

	reg_idx_t idx;
	cfg_t cfg_q;
	logic wr;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_db <= THRESHOLD_RST;
			cfg_q.range_db <= RANGE_RST;
			cfg_q.ratio <= RATIO_RST;
			cfg_q.attack_coef <= ATTACK_RST;
			cfg_q.release_coef <= RELEASE_RST;
			cfg_q.hold_samples <= HOLD_RST;
		end else if (wr) begin
			case (idx)
				REG_THRESHOLD: cfg_q.threshold_db <= pwdata[15:0];
				REG_RANGE: cfg_q.range_db <= pwdata[14:0];
				REG_RATIO: cfg_q.ratio <= pwdata[12:0];
				REG_ATTACK: cfg_q.attack_coef <= pwdata[15:0];
				REG_RELEASE: cfg_q.release_coef <= pwdata[15:0];
				REG_HOLD: cfg_q.hold_samples <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THRESHOLD: prdata = {16'd0, cfg_q.threshold_db};
			REG_RANGE: prdata = {17'd0, cfg_q.range_db};
			REG_RATIO: prdata = {19'd0, cfg_q.ratio};
			REG_ATTACK: prdata = {16'd0, cfg_q.attack_coef};
			REG_RELEASE: prdata = {16'd0, cfg_q.release_coef};
			REG_HOLD: prdata = {15'd0, cfg_q.hold_samples};
			default: prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/noise_gate_expander.sv -----
// Top level of the stereo-linked noise gate and downward expander with hold.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid/in_stall    left_sample, right_sample
//   output    out        out_valid/out_stall  left_out, right_out, gain, gate_open
//   config    in         psel/penable/pready  paddr, pwdata, prdata
//
// A request passes through envelope update, a bit-shifting normalisation of the envelope,
// dB conversion, the gain-reduction and exponent steps when the gate is expanding, gain
// smoothing and the left and right products, all sharing the single multiplier.
// Reset clears the envelope to one LSB, the gain to 0.01 and the hold counter.
// A finished result waits in the output register while the next request is taken in the
// cycle after the load; the sequencer only stalls at its last step if that result is still held.
`default_nettype none
module noise_gate_expander #(
	parameter int SAMPLE_BITS = 24,
	parameter int LOG_TABLE_BITS = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0]      left_out,
	output logic signed [SAMPLE_BITS-1:0]      right_out,
	output logic [17:0]                        gain,
	output logic                               gate_open,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [nge_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import nge_pkg::*;

	localparam int KW = $clog2(LOG_TABLE_BITS);
	localparam int PW = 2 * MUL_W;
	localparam logic signed [PW-1:0] S_HI =
		{{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [PW-1:0] S_LO = ~S_HI;
	localparam logic signed [PW-1:0] DB_LO_W = PW'(DB_LOWEST);
	localparam logic signed [PW-1:0] DB_HI_W = PW'(DB_HIGHEST);

	cfg_t cfg;

	nge_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// Constant tables, worked out at elaboration.
	logic [15:0] log_tab [2**LOG_TABLE_BITS];
	logic [31:0] root_tab [LOG_TABLE_BITS];

	for (genvar g = 0; g < 2**LOG_TABLE_BITS; g++) begin : g_log
		localparam logic [15:0] LV = log2_frac(g, LOG_TABLE_BITS);
		assign log_tab[g] = LV;
	end
	for (genvar g = 0; g < LOG_TABLE_BITS; g++) begin : g_root
		localparam logic [31:0] RV = exp_root(g + 1);
		assign root_tab[g] = RV;
	end

	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [PW-1:0] mul_p;

	nge_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_p));

	state_t st_q, st_n;

	logic signed [SAMPLE_BITS-1:0] l_q, r_q;
	logic [31:0] rect_q, env_q, norm_q;
	logic [4:0] msb_q;
	logic zero_q;
	logic [16:0] hold_q;
	logic open_q;
	logic [15:0] under_q;
	logic [14:0] gr_q;
	logic [4:0] oct_q;
	logic [15:0] frac_q;
	logic [32:0] m_q;
	logic [KW-1:0] k_q;
	logic [17:0] target_q, sg_q;
	logic signed [SAMPLE_BITS-1:0] lres_q;
	logic signed [SAMPLE_BITS-1:0] lo_q, ro_q;
	logic [17:0] gain_q;
	logic gate_q, out_valid_q;

	// Combinational datapath terms.
	logic [SAMPLE_BITS-1:0] ml, mr, mmax;
	logic env_up, g_up;
	logic [15:0] coef_env, coef_g;
	logic [31:0] diff_env, step_env, env_n;
	logic [17:0] diff_g, step_g;
	logic signed [6:0] exp_s;
	logic signed [22:0] l2;
	logic signed [PW-1:0] db_full, ys;
	logic signed [15:0] db_n, thr;
	logic signed [16:0] under_w;
	logic [12:0] rat_m1;
	logic [20:0] gr_w;
	logic [5:0] shift;
	logic [37:0] round_sum;
	logic signed [SAMPLE_BITS-1:0] sat_y;
	logic load_out;

	assign ml = left_sample[SAMPLE_BITS-1] ? (~left_sample + 1'b1) : left_sample;
	assign mr = right_sample[SAMPLE_BITS-1] ? (~right_sample + 1'b1) : right_sample;
	assign mmax = (ml > mr) ? ml : mr;

	assign env_up = rect_q > env_q;
	assign coef_env = env_up ? cfg.attack_coef : cfg.release_coef;
	assign diff_env = env_up ? (rect_q - env_q) : (env_q - rect_q);
	assign step_env = 32'((mul_p[48:0] + 49'd65535) >> 16);
	assign env_n = env_up ? (env_q + step_env) : (env_q - step_env);

	assign g_up = target_q > sg_q;
	assign coef_g = g_up ? cfg.attack_coef : cfg.release_coef;
	assign diff_g = g_up ? (target_q - sg_q) : (sg_q - target_q);
	assign step_g = 18'((mul_p[34:0] + 35'd65535) >> 16);

	// log2 of the normalised envelope: integer part from the leading one, fraction from table.
	assign exp_s = $signed({2'b00, msb_q}) - 7'sd31;
	assign l2 = $signed({exp_s, log_tab[norm_q[30 -: LOG_TABLE_BITS]]});

	assign db_full = mul_p >>> 20;
	always_comb begin
		if (zero_q || db_full < DB_LO_W) begin
			db_n = 16'sh8000;
		end else if (db_full > DB_HI_W) begin
			db_n = 16'sh7FFF;
		end else begin
			db_n = db_full[15:0];
		end
	end
	assign thr = $signed(cfg.threshold_db);
	assign under_w = 17'(thr) - 17'(db_n);
	assign rat_m1 = (cfg.ratio < RATIO_ONE) ? 13'd0 : (cfg.ratio - RATIO_ONE);
	assign gr_w = mul_p[28:8];

	assign shift = 6'd15 + {1'b0, oct_q};
	assign round_sum = {5'd0, m_q} + (38'd1 << (shift - 6'd1));

	// Output rounding, half up, then saturation to the sample width.
	assign ys = (mul_p + PW'(65536)) >>> 17;
	always_comb begin
		if (ys > S_HI) begin
			sat_y = S_HI[SAMPLE_BITS-1:0];
		end else if (ys < S_LO) begin
			sat_y = S_LO[SAMPLE_BITS-1:0];
		end else begin
			sat_y = ys[SAMPLE_BITS-1:0];
		end
	end

	assign load_out = (st_q == S_R_UPD) && !(out_valid_q && out_stall);

	// Next state.
	always_comb begin
		st_n = st_q;
		case (st_q)
			S_IDLE: if (in_valid) st_n = S_ENV_MUL;
			S_ENV_MUL: st_n = S_ENV_UPD;
			S_ENV_UPD: st_n = S_NORM;
			S_NORM: if (norm_q == 32'd0 || norm_q[31]) st_n = S_DB_MUL;
			S_DB_MUL: st_n = S_DB;
			S_DB: begin
				if (db_n >= thr || hold_q != 17'd0) st_n = S_G_MUL;
				else st_n = S_GR_MUL;
			end
			S_GR_MUL: st_n = S_GR;
			S_GR: st_n = S_E_MUL;
			S_E_MUL: st_n = S_E;
			S_E: st_n = S_EXP_MUL;
			S_EXP_MUL: st_n = S_EXP_UPD;
			S_EXP_UPD: begin
				if (k_q == KW'(LOG_TABLE_BITS - 1)) st_n = S_TGT;
				else st_n = S_EXP_MUL;
			end
			S_TGT: st_n = S_G_MUL;
			S_G_MUL: st_n = S_G_UPD;
			S_G_UPD: st_n = S_L_MUL;
			S_L_MUL: st_n = S_L_UPD;
			S_L_UPD: st_n = S_R_MUL;
			S_R_MUL: st_n = S_R_UPD;
			S_R_UPD: if (load_out) st_n = S_IDLE;
			default: st_n = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and multiplier operands.
	always_comb begin
		in_stall = (st_q != S_IDLE);
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_ENV_MUL: begin
				mul_a = MUL_W'(17'd65536 - {1'b0, coef_env});
				mul_b = MUL_W'(diff_env);
			end
			S_DB_MUL: begin
				mul_a = MUL_W'(l2);
				mul_b = MUL_W'(DB_PER_OCTAVE_Q12);
			end
			S_GR_MUL: begin
				mul_a = MUL_W'(under_q);
				mul_b = MUL_W'(rat_m1);
			end
			S_E_MUL: begin
				mul_a = MUL_W'(gr_q);
				mul_b = MUL_W'(OCTAVE_PER_DB_Q16);
			end
			S_EXP_MUL: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(root_tab[k_q]);
			end
			S_G_MUL: begin
				mul_a = MUL_W'(17'd65536 - {1'b0, coef_g});
				mul_b = MUL_W'(diff_g);
			end
			S_L_MUL: begin
				mul_a = MUL_W'(l_q);
				mul_b = MUL_W'(sg_q);
			end
			S_R_MUL, S_R_UPD: begin
				mul_a = MUL_W'(r_q);
				mul_b = MUL_W'(sg_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			env_q <= ENV_RST;
			sg_q <= GAIN_RST;
			hold_q <= 17'd0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (st_q == S_ENV_UPD) env_q <= env_n;
			if (st_q == S_G_UPD) sg_q <= g_up ? (sg_q + step_g) : (sg_q - step_g);
			if (st_q == S_DB) begin
				if (db_n >= thr) hold_q <= cfg.hold_samples;
				else if (hold_q != 17'd0) hold_q <= hold_q - 17'd1;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				l_q <= left_sample;
				r_q <= right_sample;
				rect_q <= 32'(mmax) << (32 - SAMPLE_BITS);
			end
			S_ENV_UPD: begin
				norm_q <= env_n;
				msb_q <= 5'd31;
				zero_q <= (env_n == 32'd0);
			end
			S_NORM: begin
				if (norm_q != 32'd0 && !norm_q[31]) begin
					if (norm_q[31:24] == 8'd0) begin
						norm_q <= norm_q << 8;
						msb_q <= msb_q - 5'd8;
					end else begin
						norm_q <= norm_q << 1;
						msb_q <= msb_q - 5'd1;
					end
				end
			end
			S_DB: begin
				open_q <= (db_n >= thr) || (hold_q != 17'd0);
				target_q <= UNITY_GAIN;
				under_q <= under_w[15:0];
			end
			S_GR: gr_q <= (gr_w > 21'(cfg.range_db)) ? cfg.range_db : gr_w[14:0];
			S_E: begin
				oct_q <= gr_w[20:16];
				frac_q <= gr_w[15:0];
				m_q <= 33'h1_0000_0000;
				k_q <= '0;
			end
			S_EXP_UPD: begin
				if (frac_q[15]) m_q <= mul_p[64:32];
				frac_q <= frac_q << 1;
				k_q <= k_q + 1'b1;
			end
			S_TGT: target_q <= 18'(round_sum >> shift);
			S_L_UPD: lres_q <= sat_y;
			S_R_UPD: begin
				if (load_out) begin
					lo_q <= lres_q;
					ro_q <= sat_y;
					gain_q <= sg_q;
					gate_q <= open_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign left_out = lo_q;
	assign right_out = ro_q;
	assign gain = gain_q;
	assign gate_open = gate_q;

endmodule
`default_nettype wire

// ----- rtl/core/nge_chk.sv -----
// Port-level checker for the noise gate, bound to the top level.
`default_nettype none
module nge_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [17:0] gain,
	input wire logic        gate_open
);
	import nge_pkg::*;

	// A held result keeps its gain and gate flag.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(gain) && $stable(gate_open))
		else $error("held result changed");

	// The smoothed gain never exceeds unity.
	a_gain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gain <= UNITY_GAIN)
		else $error("gain above unity");

	// A request keeps the sequencer busy in the following cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer not busy after request");

	// A new result appears only as the sequencer becomes free.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result appeared while busy");

endmodule

bind noise_gate_expander nge_chk u_nge_chk (.*);
`default_nettype wire
